@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/trm_pkg.sv @@
package trm_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ByteW = 8;
	localparam int unsigned NumByteRegs = 4;
	localparam int unsigned NumWordRegs = 6;

	// Opcodes.
	localparam logic [3:0] OP_NOOP     = 4'd0;
	localparam logic [3:0] OP_SET      = 4'd1;
	localparam logic [3:0] OP_SUM      = 4'd2;
	localparam logic [3:0] OP_SUB      = 4'd3;
	localparam logic [3:0] OP_JNZ      = 4'd4;
	localparam logic [3:0] OP_MOV_IN   = 4'd5;
	localparam logic [3:0] OP_MOV_OUT  = 4'd6;
	localparam logic [3:0] OP_COPY_MEM = 4'd7;
	localparam logic [3:0] OP_EXIT     = 4'd8;
	localparam logic [3:0] OP_SYSCALL  = 4'd9;

	// Register selects.
	localparam logic [3:0] SEL_PC        = 4'd0;
	localparam logic [3:0] SEL_BYTE_LO   = 4'd1;
	localparam logic [3:0] SEL_BYTE_HI   = 4'd4;
	localparam logic [3:0] SEL_WORD_LO   = 4'd5;
	localparam logic [3:0] SEL_WORD_HI   = 4'd10;

	// Stop reasons.
	localparam logic [2:0] WHY_NONE    = 3'd0;
	localparam logic [2:0] WHY_SYSCALL = 3'd1;
	localparam logic [2:0] WHY_ERROR   = 3'd3;
	localparam logic [2:0] WHY_EXIT    = 3'd4;

	// Argument counts required by the two instruction groups.
	localparam logic [1:0] ARGS_ALU = 2'd3;
	localparam logic [1:0] ARGS_MEM = 2'd2;

	typedef struct packed {
		logic [3:0]       cmd;
		logic [3:0]       reg_a;
		logic [3:0]       reg_b;
		logic [WordW-1:0] immediate;
		logic [1:0]       arg_count;
		logic             irq_pending;
		logic [2:0]       irq_reason;
	} item_t;

	typedef struct packed {
		logic             stop;
		logic [2:0]       reason;
		logic [WordW-1:0] pc_out;
		logic [WordW-1:0] dest_value;
	} result_t;

	// State update decided by the execute logic for one instruction.
	typedef struct packed {
		logic             ok;
		logic             we;
		logic [3:0]       sel;
		logic [WordW-1:0] data;
		logic [WordW-1:0] pc_next;
	} exec_t;

endpackage

@@ hw/rtl/trm_regfile.sv @@
module trm_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [3:0]                 rd_sel_a,
	input  logic [3:0]                 rd_sel_b,
	output logic [trm_pkg::WordW-1:0]  rd_data_a,
	output logic [trm_pkg::WordW-1:0]  rd_data_b,
	output logic [trm_pkg::WordW-1:0]  pc,
	input  logic                       commit,
	input  trm_pkg::exec_t             upd
);
	import trm_pkg::*;

	logic [WordW-1:0]                  pc_q;
	logic [NumByteRegs-1:0][ByteW-1:0] byte_q;
	logic [NumWordRegs-1:0][WordW-1:0] word_q;
	logic [3:0]                        wr_byte_off;
	logic [3:0]                        wr_word_off;

	// Unknown selects read as zero.
	function automatic logic [WordW-1:0] pick(
		input logic [3:0]                        sel,
		input logic [WordW-1:0]                  pc_v,
		input logic [NumByteRegs-1:0][ByteW-1:0] bregs,
		input logic [NumWordRegs-1:0][WordW-1:0] wregs
	);
		logic [3:0]       boff;
		logic [3:0]       woff;
		logic [WordW-1:0] val;
		boff = sel - SEL_BYTE_LO;
		woff = sel - SEL_WORD_LO;
		val  = '0;
		if (sel == SEL_PC) begin
			val = pc_v;
		end else if (sel inside {[SEL_BYTE_LO:SEL_BYTE_HI]}) begin
			val = {{(WordW-ByteW){1'b0}}, bregs[boff[1:0]]};
		end else if (sel inside {[SEL_WORD_LO:SEL_WORD_HI]}) begin
			val = wregs[woff[2:0]];
		end
		return val;
	endfunction

	assign rd_data_a = pick(rd_sel_a, pc_q, byte_q, word_q);
	assign rd_data_b = pick(rd_sel_b, pc_q, byte_q, word_q);
	assign pc        = pc_q;

	assign wr_byte_off = upd.sel - SEL_BYTE_LO;
	assign wr_word_off = upd.sel - SEL_WORD_LO;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			byte_q <= '0;
			word_q <= '0;
		end else if (commit) begin
			pc_q <= upd.pc_next;
			if (upd.we) begin
				if (upd.sel inside {[SEL_BYTE_LO:SEL_BYTE_HI]}) begin
					byte_q[wr_byte_off[1:0]] <= upd.data[ByteW-1:0];
				end else if (upd.sel inside {[SEL_WORD_LO:SEL_WORD_HI]}) begin
					word_q[wr_word_off[2:0]] <= upd.data;
				end
			end
		end
	end

endmodule

@@ hw/rtl/trm_exec.sv @@
module trm_exec (
	input  trm_pkg::item_t             item,
	input  logic [trm_pkg::WordW-1:0]  pc,
	input  logic [trm_pkg::WordW-1:0]  a_val,
	input  logic [trm_pkg::WordW-1:0]  b_val,
	output trm_pkg::exec_t             upd,
	output trm_pkg::result_t           result
);
	import trm_pkg::*;

	logic             ok;
	logic [2:0]       why;
	logic             jumped;
	logic             write;
	logic [WordW-1:0] wval;
	logic [WordW-1:0] pc_base;
	logic [WordW-1:0] pc_next;
	logic             is_byte;
	logic             is_word;

	always_comb begin
		ok     = 1'b1;
		why    = WHY_NONE;
		jumped = 1'b0;
		write  = 1'b0;
		wval   = item.immediate;
		case (item.cmd)
			OP_NOOP: begin
			end
			OP_SET, OP_SUM, OP_SUB, OP_JNZ: begin
				if (item.arg_count < ARGS_ALU) begin
					ok  = 1'b0;
					why = WHY_ERROR;
				end else if (item.cmd == OP_SET) begin
					write = 1'b1;
				end else if (item.cmd == OP_SUM) begin
					write = 1'b1;
					wval  = a_val + b_val;
				end else if (item.cmd == OP_SUB) begin
					write = 1'b1;
					wval  = a_val - b_val;
				end else begin
					jumped = (a_val != '0);
				end
			end
			OP_MOV_IN, OP_MOV_OUT, OP_COPY_MEM: begin
				if (item.arg_count < ARGS_MEM) begin
					ok  = 1'b0;
					why = WHY_ERROR;
				end
			end
			OP_EXIT: begin
				ok  = 1'b0;
				why = WHY_EXIT;
			end
			OP_SYSCALL: begin
				ok  = 1'b0;
				why = WHY_SYSCALL;
			end
			default: begin
				ok  = 1'b0;
				why = WHY_ERROR;
			end
		endcase
	end

	assign is_byte = item.reg_a inside {[SEL_BYTE_LO:SEL_BYTE_HI]};
	assign is_word = item.reg_a inside {[SEL_WORD_LO:SEL_WORD_HI]};

	// A write to the PC still takes the normal advance afterwards.
	assign pc_base = (write && item.reg_a == SEL_PC) ? wval : pc;

	always_comb begin
		if (!ok) begin
			pc_next = pc;
		end else if (jumped) begin
			pc_next = item.immediate;
		end else begin
			pc_next = pc_base + 1'b1;
		end
	end

	assign upd.ok      = ok;
	assign upd.we      = write && (is_byte || is_word);
	assign upd.sel     = item.reg_a;
	assign upd.data    = wval;
	assign upd.pc_next = pc_next;

	always_comb begin
		result.stop   = !ok || item.irq_pending;
		result.reason = !ok ? why : (item.irq_pending ? item.irq_reason : WHY_NONE);
		result.pc_out = pc_next;
		if (item.reg_a == SEL_PC) begin
			result.dest_value = pc_next;
		end else if (write && is_byte) begin
			result.dest_value = {{(WordW-ByteW){1'b0}}, wval[ByteW-1:0]};
		end else if (write && is_word) begin
			result.dest_value = wval;
		end else begin
			result.dest_value = a_val;
		end
	end

endmodule

@@ hw/rtl/toy_register_machine_execute.sv @@
// Execute stage of a small register machine.
// Input channel (item_valid, item_stall, item) carries one decoded instruction per
// beat: opcode, two register selects, an immediate, the argument count and the
// interrupt status. Output channel (result_valid, result_stall, result) returns one
// beat per instruction: stop flag, stop reason, the new PC and the value that the
// first named register holds after the instruction.
// An accepted beat is captured in an input register and executed against the register
// file from there; its outcome lands in the result register when it commits, which a
// stalled, full result register holds off. One instruction is accepted per cycle
// while item_stall is low; the limit is the single add or subtract and the PC
// increment between the input register and the result register.
// Instructions see the register file as left by all earlier ones, in order.
// Reset clears the PC and all registers to zero and empties both pipeline stages.
// When the receiver stalls, the result register holds its beat; the input register
// can still move one instruction into the result register once it frees up, and
// item_stall rises only while both stages are full and the output is stalled.
`include "assert_macros.svh"

module toy_register_machine_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  trm_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output trm_pkg::result_t  result
);
	import trm_pkg::*;

	// Input register stage.
	logic    valid_s1;
	item_t   item_s1;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	// Register file interface.
	logic [WordW-1:0] a_val;
	logic [WordW-1:0] b_val;
	logic [WordW-1:0] pc;
	exec_t            upd;
	result_t          exec_result;

	// The instruction in the input register executes and retires when the result
	// register is empty or is being drained in this cycle.
	logic commit;

	assign commit     = valid_s1 && !(result_valid_q && result_stall);
	assign item_stall = valid_s1 && !commit;

	trm_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_sel_a  (item_s1.reg_a),
		.rd_sel_b  (item_s1.reg_b),
		.rd_data_a (a_val),
		.rd_data_b (b_val),
		.pc        (pc),
		.commit    (commit),
		.upd       (upd)
	);

	trm_exec u_exec (
		.item   (item_s1),
		.pc     (pc),
		.a_val  (a_val),
		.b_val  (b_val),
		.upd    (upd),
		.result (exec_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid bits qualify them.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (commit) begin
			result_q <= exec_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Backpressure only ever comes from a full input register.
	`ASSERT_IMPLIES(a_stall_needs_item, item_stall, valid_s1)
	// A retired instruction always shows up in the result register next cycle.
	`ASSERT_NEXT(a_commit_fills_result, commit, result_valid_q)
	// A failed or stopping-by-opcode instruction leaves the PC untouched.
	`ASSERT_NEXT(a_fail_keeps_pc, commit && !upd.ok, pc == $past(pc))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Checks the execute stage of the small register machine against a predictor
// that keeps its own copy of the PC and the register file. Every instruction
// beat accepted on the input channel is retired in the predictor, and the
// resulting expectation is queued. Every result beat accepted on the output
// channel is checked field by field against the oldest queued expectation.
// A short directed sequence comes first. After it, four random phases follow,
// each with its own amount of sender idling and receiver stalling.
module tb;
	import trm_pkg::*;

	// The first codes past the defined opcodes and register selects.
	localparam logic [3:0] FIRST_UNUSED_OP  = OP_SYSCALL + 4'd1;
	localparam logic [3:0] FIRST_UNUSED_SEL = SEL_WORD_HI + 4'd1;

	// Names used by the directed sequence.
	localparam logic [3:0] SEL_AX  = SEL_BYTE_LO;
	localparam logic [3:0] SEL_BX  = SEL_BYTE_LO + 4'd1;
	localparam logic [3:0] SEL_DX  = SEL_BYTE_HI;
	localparam logic [3:0] SEL_EAX = SEL_WORD_LO;
	localparam logic [3:0] SEL_EBX = SEL_WORD_LO + 4'd1;
	localparam logic [3:0] SEL_EDX = SEL_WORD_LO + 4'd3;
	localparam logic [3:0] SEL_DI  = SEL_WORD_HI;

	localparam int unsigned RANDOM_PER_PHASE = 125;

	// Keeps the predicted machine state and the results that are still due.
	class exec_scoreboard;
		logic [WordW-1:0] pc;
		logic [ByteW-1:0] byte_reg [NumByteRegs];
		logic [WordW-1:0] word_reg [NumWordRegs];
		result_t          due_results [$];
		int unsigned      errors;

		function new();
			pc = '0;
			foreach (byte_reg[i]) byte_reg[i] = '0;
			foreach (word_reg[i]) word_reg[i] = '0;
			errors = 0;
		endfunction

		// Unknown selects read as zero.
		function logic [WordW-1:0] read_reg(logic [3:0] sel);
			if (sel == SEL_PC) return pc;
			if (sel >= SEL_BYTE_LO && sel <= SEL_BYTE_HI)
				return WordW'(byte_reg[sel - SEL_BYTE_LO]);
			if (sel >= SEL_WORD_LO && sel <= SEL_WORD_HI)
				return word_reg[sel - SEL_WORD_LO];
			return '0;
		endfunction

		// Byte registers keep the low byte; unknown selects drop the write.
		function void write_reg(logic [3:0] sel, logic [WordW-1:0] value);
			if (sel == SEL_PC) pc = value;
			else if (sel >= SEL_BYTE_LO && sel <= SEL_BYTE_HI)
				byte_reg[sel - SEL_BYTE_LO] = value[ByteW-1:0];
			else if (sel >= SEL_WORD_LO && sel <= SEL_WORD_HI)
				word_reg[sel - SEL_WORD_LO] = value;
		endfunction

		// Applies one instruction to the predicted state and returns its result.
		function result_t retire_instruction(item_t it);
			result_t r;
			logic    ok;
			logic    jumped;
			r.stop = 1'b0;
			r.reason = WHY_NONE;
			ok = 1'b1;
			jumped = 1'b0;
			case (it.cmd)
				OP_NOOP: ;
				OP_SET, OP_SUM, OP_SUB, OP_JNZ: begin
					if (it.arg_count < ARGS_ALU) begin
						ok = 1'b0;
						r.reason = WHY_ERROR;
					end else begin
						case (it.cmd)
							OP_SET: write_reg(it.reg_a, it.immediate);
							OP_SUM: write_reg(it.reg_a, read_reg(it.reg_a) + read_reg(it.reg_b));
							OP_SUB: write_reg(it.reg_a, read_reg(it.reg_a) - read_reg(it.reg_b));
							default: begin
								if (read_reg(it.reg_a) != '0) begin
									pc = it.immediate;
									jumped = 1'b1;
								end
							end
						endcase
					end
				end
				OP_MOV_IN, OP_MOV_OUT, OP_COPY_MEM: begin
					if (it.arg_count < ARGS_MEM) begin
						ok = 1'b0;
						r.reason = WHY_ERROR;
					end
				end
				OP_EXIT: begin
					ok = 1'b0;
					r.reason = WHY_EXIT;
				end
				OP_SYSCALL: begin
					ok = 1'b0;
					r.reason = WHY_SYSCALL;
				end
				default: begin
					ok = 1'b0;
					r.reason = WHY_ERROR;
				end
			endcase
			// A stopping instruction leaves the PC alone and ignores the interrupt.
			if (ok) begin
				if (!jumped) pc = pc + 1'b1;
				if (it.irq_pending) begin
					r.stop = 1'b1;
					r.reason = it.irq_reason;
				end
			end else begin
				r.stop = 1'b1;
			end
			r.pc_out = pc;
			r.dest_value = read_reg(it.reg_a);
			return r;
		endfunction

		function void note_instruction(item_t it);
			due_results.push_back(retire_instruction(it));
		endfunction

		function void compare_field(string field, logic [WordW-1:0] want,
				logic [WordW-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result beat with nothing due, actual %h", $time, got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("stop", WordW'(want.stop), WordW'(got.stop));
			compare_field("reason", WordW'(want.reason), WordW'(got.reason));
			compare_field("pc_out", want.pc_out, got.pc_out);
			compare_field("dest_value", want.dest_value, got.dest_value);
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	exec_scoreboard sb = new();

	toy_register_machine_execute u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random, at the rate of the current phase. With a
	// rate of zero the output channel never stalls.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Both channels are observed at the rising edge, before any nonblocking
	// update of that edge lands, so the values seen are the ones that decide
	// whether a beat moved. The input is noted before the output is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.note_instruction(item);
			if (result_valid && !result_stall) sb.check_result(result);
		end
	end

	// Offers one instruction beat and returns at the edge where it is taken.
	// Valid is not dropped here, so back-to-back beats keep it high with a
	// single assignment per edge; an idle cycle lowers it instead.
	task automatic push_instruction(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic issue(input logic [3:0] cmd, input logic [3:0] ra, input logic [3:0] rb,
			input logic [WordW-1:0] imm, input logic [1:0] argc,
			input logic irq = 1'b0, input logic [2:0] irq_why = WHY_NONE);
		item_t it;
		it.cmd = cmd;
		it.reg_a = ra;
		it.reg_b = rb;
		it.immediate = imm;
		it.arg_count = argc;
		it.irq_pending = irq;
		it.irq_reason = irq_why;
		push_instruction(it);
	endtask

	// The sender goes quiet until every result that is due has come back.
	task automatic await_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// Mostly defined registers, now and then one of the unknown selects.
	function automatic logic [3:0] random_sel();
		if ($urandom_range(99) < 85) return 4'($urandom_range(int'(SEL_WORD_HI)));
		return 4'($urandom_range(15, int'(FIRST_UNUSED_SEL)));
	endfunction

	// Most beats are well formed arithmetic and jumps with random operands, so
	// the register file keeps changing; the rest are no-ops, stops, memory moves,
	// missing arguments and pending interrupts.
	function automatic item_t random_instruction();
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20) it.cmd = OP_SET;
		else if (pick < 40) it.cmd = OP_SUM;
		else if (pick < 60) it.cmd = OP_SUB;
		else if (pick < 72) it.cmd = OP_JNZ;
		else if (pick < 77) it.cmd = OP_NOOP;
		else if (pick < 86) it.cmd = OP_MOV_IN + 4'($urandom_range(2));
		else if (pick < 90) it.cmd = OP_EXIT;
		else if (pick < 94) it.cmd = OP_SYSCALL;
		else it.cmd = 4'($urandom_range(15, int'(FIRST_UNUSED_OP)));
		it.reg_a = random_sel();
		it.reg_b = random_sel();
		case ($urandom_range(3))
			0: it.immediate = '0;
			1: it.immediate = '1;
			2: it.immediate = WordW'($urandom_range(255));
			default: it.immediate = $urandom;
		endcase
		it.arg_count = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : ARGS_ALU;
		it.irq_pending = ($urandom_range(9) == 0);
		it.irq_reason = 3'($urandom);
		return it;
	endfunction

	initial begin
		int unsigned phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		issue(OP_NOOP, SEL_PC, SEL_PC, '0, 2'd0);
		// Writes at the field extremes; byte registers keep only the low byte.
		issue(OP_SET, SEL_AX, SEL_PC, '1, ARGS_ALU);
		issue(OP_SET, SEL_DX, SEL_PC, 32'h0000_0180, ARGS_ALU);
		issue(OP_SET, SEL_EAX, SEL_PC, '1, ARGS_ALU);
		issue(OP_SET, SEL_DI, SEL_PC, 32'h8000_0001, ARGS_ALU);
		// A write to an unknown register is dropped and it reads back as zero.
		issue(OP_SET, FIRST_UNUSED_SEL, SEL_PC, 32'h1234_5678, ARGS_ALU);
		// Sums and differences that wrap, in both widths.
		issue(OP_SUM, SEL_AX, SEL_AX, '0, ARGS_ALU);
		issue(OP_SUM, SEL_EAX, SEL_DI, '0, ARGS_ALU);
		issue(OP_SUB, SEL_BX, SEL_AX, '0, ARGS_ALU);
		issue(OP_SUB, SEL_EBX, SEL_EAX, '0, ARGS_ALU);
		issue(OP_SUM, SEL_DX, 4'hF, '0, ARGS_ALU);
		// A jump not taken, then one taken to the top of the address range,
		// after which a plain step wraps the PC to zero.
		issue(OP_JNZ, SEL_EDX, SEL_PC, 32'h0000_0005, ARGS_ALU);
		issue(OP_JNZ, SEL_DI, SEL_PC, '1, ARGS_ALU);
		issue(OP_NOOP, SEL_PC, SEL_PC, '0, ARGS_ALU);
		// Writing the PC still lets it advance by one afterwards.
		issue(OP_SET, SEL_PC, SEL_PC, 32'd100, ARGS_ALU);
		issue(OP_SUM, SEL_PC, SEL_EAX, '0, ARGS_ALU);
		// Missing arguments stop with an error and change nothing.
		issue(OP_SET, SEL_EAX, SEL_PC, 32'hDEAD_BEEF, ARGS_MEM);
		issue(OP_JNZ, SEL_DI, SEL_PC, 32'h0000_0040, 2'd0);
		issue(OP_MOV_IN, SEL_AX, SEL_BX, '0, 2'd1);
		// Memory moves with enough arguments behave as a plain step.
		issue(OP_MOV_OUT, SEL_AX, SEL_BX, '0, ARGS_MEM);
		issue(OP_COPY_MEM, SEL_EAX, SEL_BX, '0, ARGS_ALU);
		// Stopping instructions, one of them with an interrupt that must be ignored.
		issue(OP_EXIT, SEL_DI, SEL_PC, '0, ARGS_ALU, 1'b1, 3'd2);
		issue(OP_SYSCALL, SEL_EAX, SEL_PC, '0, ARGS_ALU);
		issue(FIRST_UNUSED_OP, SEL_EAX, SEL_PC, '0, ARGS_ALU);
		issue(4'hF, SEL_AX, SEL_PC, '0, ARGS_ALU);
		// Interrupts after a good step pass their reason through, even odd ones.
		issue(OP_SUB, SEL_DX, SEL_AX, '0, ARGS_ALU, 1'b1, 3'd7);
		issue(OP_NOOP, SEL_PC, SEL_PC, '0, ARGS_ALU, 1'b1, WHY_NONE);
		await_drain();

		// Random phases: no idling, a mostly idle sender, a mostly stalling
		// receiver, then both at a moderate rate. Each ends with a full drain.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			repeat (RANDOM_PER_PHASE) push_instruction(random_instruction());
			await_drain();
		end

		// Keep the clock running with the receiver ready so that a stray extra beat would be seen.
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	// Hard limit, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("tb: errors");
		$finish;
	end

endmodule
